[hdl/gem_pkg.sv]
`default_nettype none

package gem_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_EVENT  = 1'b1;
    localparam logic [7:0] KIND_AXIS = 8'd2;
    localparam int         INIT_BIT  = 7;

    // table entry without its valid mark; valid marks live in flops
    typedef struct packed {
        logic [7:0]         code;
        logic [1:0]         kind;
        logic [7:0]         control;
        logic signed [1:0]  direction;
        logic signed [15:0] deadzone;
    } entry_t;

    typedef struct packed {
        logic               match;
        logic               stop;
        logic signed [15:0] level;
    } match_t;

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_SCAN_MAIN  = 6'b000010,
        S_SCAN_POS   = 6'b000100,
        S_SCAN_NEG   = 6'b001000,
        S_OUT_FIRST  = 6'b010000,
        S_OUT_SECOND = 6'b100000
    } state_t;

endpackage

`default_nettype wire

[hdl/gamepad_event_mapper.sv]
`default_nettype none

// Load request: writes one table slot, no result.
// Event request: a table scan reads the slots in order through the one-port table read and
// the single match unit, and ends at an unused slot, a match with nonzero code, or past the
// last slot. Results follow the last scan; an axis settling at zero runs three scans.
// One event in flight; input stalls until its results are taken. Reset clears every table
// valid mark, the press flag and the sequencer.

module gamepad_event_mapper (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire                 operation,
    input  wire  [5:0]          entry_index,
    input  wire                 entry_valid,
    input  wire  [7:0]          entry_code,
    input  wire  [1:0]          entry_kind,
    input  wire  [7:0]          entry_control,
    input  wire  signed [1:0]   entry_direction,
    input  wire  signed [15:0]  entry_deadzone,
    input  wire  [7:0]          event_kind,
    input  wire  [7:0]          event_control,
    input  wire  signed [15:0]  event_level,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [7:0]          key_code,
    output logic signed [15:0]  key_level,
    output logic                last_result,
    output logic                any_press_seen
);

    import gem_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     pend_reg, pend_next;
    logic                     two_reg, two_next;
    logic                     press_reg, press_next;
    logic [TABLE_ENTRIES-1:0] vbits_reg;
    logic                     vbit_reg;
    logic [7:0]               kind_reg;
    logic [7:0]               control_reg;
    logic signed [15:0]       level_reg, level_next;
    logic [7:0]               found_reg, found_next;
    logic [7:0]               code1_reg, code1_next;
    logic [7:0]               code2_reg, code2_next;

    entry_t                   wr_entry;
    entry_t                   rd_entry;
    match_t                   mres;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         wr_addr;
    logic                     accept;
    logic                     load_we;
    logic                     start_event;
    logic                     scanning;
    logic                     hit;
    logic                     scan_done;
    logic                     issue;
    logic signed [15:0]       lvl_scan;
    logic [7:0]               found_scan;

    assign accept      = in_valid && !in_stall;
    assign load_we     = accept && (operation == OP_LOAD)
                         && (32'(entry_index) < TABLE_ENTRIES);
    assign start_event = accept && (operation == OP_EVENT) && !event_kind[INIT_BIT];
    assign wr_addr     = IDX_W'(entry_index);
    assign rd_addr     = rd_idx_reg[IDX_W-1:0];

    always_comb
    begin
        wr_entry.code      = entry_code;
        wr_entry.kind      = entry_kind;
        wr_entry.control   = entry_control;
        wr_entry.direction = entry_direction;
        wr_entry.deadzone  = entry_deadzone;
    end

    gem_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    gem_match_unit u_match (
        .entry      (rd_entry),
        .ev_kind    (kind_reg),
        .ev_control (control_reg),
        .level      (level_reg),
        .result     (mres)
    );

    assign scanning   = (state_reg == S_SCAN_MAIN) || (state_reg == S_SCAN_POS)
                        || (state_reg == S_SCAN_NEG);
    assign hit        = scanning && pend_reg && vbit_reg && mres.match;
    // scan ends on an unused slot, a match with nonzero code, or past the last slot
    assign scan_done  = scanning && (pend_reg ? (!vbit_reg || (mres.match && mres.stop))
                                              : (rd_idx_reg == CNT_W'(TABLE_ENTRIES)));
    assign issue      = scanning && !scan_done && (32'(rd_idx_reg) < TABLE_ENTRIES);
    assign lvl_scan   = hit ? mres.level : level_reg;
    assign found_scan = hit ? rd_entry.code : found_reg;

    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        pend_next   = issue;
        two_next    = two_reg;
        press_next  = press_reg;
        level_next  = level_reg;
        found_next  = found_reg;
        code1_next  = code1_reg;
        code2_next  = code2_reg;

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        if (scanning)
        begin
            level_next = lvl_scan;
            found_next = found_scan;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start_event)
                begin
                    level_next  = event_level;
                    found_next  = 8'd0;
                    rd_idx_next = '0;
                    two_next    = 1'b0;
                    state_next  = S_SCAN_MAIN;
                end
            end
            S_SCAN_MAIN:
            begin
                if (scan_done)
                begin
                    code1_next = found_scan;
                    if ((kind_reg == KIND_AXIS) && (lvl_scan == 16'sd0))
                    begin
                        level_next  = 16'sd1;
                        found_next  = 8'd0;
                        rd_idx_next = '0;
                        state_next  = S_SCAN_POS;
                    end
                    else
                    begin
                        if (lvl_scan != 16'sd0)
                        begin
                            press_next = 1'b1;
                        end
                        state_next = S_OUT_FIRST;
                    end
                end
            end
            S_SCAN_POS:
            begin
                if (scan_done)
                begin
                    code1_next  = found_scan;
                    level_next  = -16'sd1;
                    found_next  = 8'd0;
                    rd_idx_next = '0;
                    state_next  = S_SCAN_NEG;
                end
            end
            S_SCAN_NEG:
            begin
                if (scan_done)
                begin
                    code2_next = found_scan;
                    level_next = 16'sd0;
                    two_next   = 1'b1;
                    state_next = S_OUT_FIRST;
                end
            end
            S_OUT_FIRST:
            begin
                if (!out_stall)
                begin
                    state_next = two_reg ? S_OUT_SECOND : S_IDLE;
                end
            end
            S_OUT_SECOND:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            two_reg    <= 1'b0;
            press_reg  <= 1'b0;
            vbits_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            two_reg    <= two_next;
            press_reg  <= press_next;
            if (load_we)
            begin
                vbits_reg[wr_addr] <= entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        found_reg <= found_next;
        code1_reg <= code1_next;
        code2_reg <= code2_next;
        if (issue)
        begin
            vbit_reg <= vbits_reg[rd_addr];
        end
        if (start_event)
        begin
            kind_reg    <= event_kind;
            control_reg <= event_control;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = (state_reg == S_OUT_FIRST) || (state_reg == S_OUT_SECOND);
    assign key_code       = (state_reg == S_OUT_SECOND) ? code2_reg : code1_reg;
    assign key_level      = level_reg;
    assign last_result    = (state_reg == S_OUT_SECOND) || !two_reg;
    assign any_press_seen = press_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> scanning)
        else $error("table read pending outside a scan");

    a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_SECOND) |-> (level_reg == 16'sd0) && two_reg)
        else $error("second result is not a release");

    a_probe_axis: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN_POS) || (state_reg == S_SCAN_NEG)) |-> (kind_reg == KIND_AXIS))
        else $error("probe scan for a non-axis event");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rd_idx_reg) <= TABLE_ENTRIES)
        else $error("scan index past table end");
`endif

endmodule

`default_nettype wire

[hdl/gem_ram.sv]
`default_nettype none

module gem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                        clk,
    input  wire                        we,
    input  wire  [$clog2(DEPTH)-1:0]   waddr,
    input  wire  [WIDTH-1:0]           wdata,
    input  wire  [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/gem_match_unit.sv]
`default_nettype none

module gem_match_unit (
    input  wire gem_pkg::entry_t  entry,
    input  wire [7:0]             ev_kind,
    input  wire [7:0]             ev_control,
    input  wire signed [15:0]     level,
    output gem_pkg::match_t       result
);

    import gem_pkg::*;

    logic signed [15:0] sgn;
    logic signed [15:0] cmp;
    logic signed [15:0] dir_ext;
    logic signed [16:0] lvl17;
    logic signed [16:0] dz17;
    logic signed [16:0] neg_dz17;
    logic               kind_ok;

    assign sgn      = level[15] ? -16'sd1 : ((level != 16'sd0) ? 16'sd1 : 16'sd0);
    assign cmp      = (ev_kind == KIND_AXIS) ? sgn : level;
    assign dir_ext  = 16'(entry.direction);
    assign lvl17    = 17'(level);
    assign dz17     = 17'(entry.deadzone);
    assign neg_dz17 = -dz17;
    // bit 7 (init) is filtered upstream; bits 6:2 must be clear to equal a 2-bit kind
    assign kind_ok  = (ev_kind[1:0] == entry.kind) && (ev_kind[6:2] == 5'd0);

    always_comb
    begin
        result.match = kind_ok && (ev_control == entry.control)
                       && ((dir_ext == cmp) || (cmp == 16'sd0));
        result.stop  = (entry.code != 8'd0);
        result.level = level;
        if (dz17 > 17'sd0)
        begin
            if ((lvl17 < dz17) && (lvl17 > neg_dz17))
            begin
                result.level = 16'sd0;
            end
        end
        else if (dz17 < 17'sd0)
        begin
            // trigger mode: threshold to 0/1
            result.level = (lvl17 < dz17) ? 16'sd0 : 16'sd1;
        end
    end

endmodule

`default_nettype wire

[bench/tb_gamepad_event_mapper.sv]
module tb_gamepad_event_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import gem_pkg::*;

    localparam logic [7:0] KIND_BUTTON = 8'd1;
    localparam int         ITEM_TARGET = 1950;
    localparam int         TAIL_ITEMS  = 200;
    localparam int         BURST_MAX   = 14;
    localparam int         SCAN_CYCLES = 3 * (TABLE_ENTRIES + 1) + 1;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic               op;
        logic [5:0]         idx;
        logic               ent_valid;
        logic [7:0]         ent_code;
        logic [1:0]         ent_kind;
        logic [7:0]         ent_ctrl;
        logic signed [1:0]  ent_dir;
        logic signed [15:0] ent_dz;
        logic [7:0]         ev_kind;
        logic [7:0]         ev_ctrl;
        logic signed [15:0] ev_level;
    } pad_req_t;

    typedef struct packed {
        logic [7:0]         code;
        logic signed [15:0] level;
        logic               last;
        logic               press;
    } key_res_t;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic               operation       = 1'b0;
    logic [5:0]         entry_index     = '0;
    logic               entry_valid     = 1'b0;
    logic [7:0]         entry_code      = '0;
    logic [1:0]         entry_kind      = '0;
    logic [7:0]         entry_control   = '0;
    logic signed [1:0]  entry_direction = '0;
    logic signed [15:0] entry_deadzone  = '0;
    logic [7:0]         event_kind      = '0;
    logic [7:0]         event_control   = '0;
    logic signed [15:0] event_level     = '0;
    logic               out_stall       = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [7:0]         key_code;
    logic signed [15:0] key_level;
    logic               last_result;
    logic               any_press_seen;

    // local copy of the key map
    logic               map_valid [TABLE_ENTRIES];
    logic [7:0]         map_code  [TABLE_ENTRIES];
    logic [1:0]         map_kind  [TABLE_ENTRIES];
    logic [7:0]         map_ctrl  [TABLE_ENTRIES];
    logic signed [1:0]  map_dir   [TABLE_ENTRIES];
    logic signed [15:0] map_dz    [TABLE_ENTRIES];
    logic               pressed_flag;

    key_res_t key_q[$];
    int       fail_count = 0;
    int       sent_count = 0;
    int       gap_pct    = 0;
    int       stall_pct  = 0;
    int       stall_left = 0;

    gamepad_event_mapper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .entry_index    (entry_index),
        .entry_valid    (entry_valid),
        .entry_code     (entry_code),
        .entry_kind     (entry_kind),
        .entry_control  (entry_control),
        .entry_direction(entry_direction),
        .entry_deadzone (entry_deadzone),
        .event_kind     (event_kind),
        .event_control  (event_control),
        .event_level    (event_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_code       (key_code),
        .key_level      (key_level),
        .last_result    (last_result),
        .any_press_seen (any_press_seen)
    );

    always #1 clk = ~clk;

    // One pass over the map; lvl may be reshaped by each matching deadzone.
    function automatic logic [7:0] lookup_code(input logic [7:0] kind,
                                               input logic [7:0] ctrl,
                                               inout int lvl);
        logic [7:0] hit;
        int         i;
        int         cmp;
        int         dir;
        int         dz;
        hit = 8'd0;
        i   = 0;
        while (i < TABLE_ENTRIES && hit == 8'd0 && map_valid[i])
        begin
            cmp = (kind == KIND_AXIS) ? ((lvl < 0) ? -1 : ((lvl > 0) ? 1 : 0)) : lvl;
            dir = int'(map_dir[i]);
            dz  = int'(map_dz[i]);
            if ({6'd0, map_kind[i]} == (kind & 8'h7F) && map_ctrl[i] == ctrl &&
                (dir == cmp || cmp == 0))
            begin
                hit = map_code[i];
                if (dz > 0)
                begin
                    if (lvl < dz && lvl > -dz)
                        lvl = 0;
                end
                else if (dz < 0)
                    lvl = (lvl < dz) ? 0 : 1;
            end
            i++;
        end
        return hit;
    endfunction

    function automatic void predict_keys(input pad_req_t r);
        logic [7:0] code_a;
        logic [7:0] code_b;
        int         lvl;
        int         probe;
        logic       both;
        if (r.op == OP_LOAD)
        begin
            map_valid[r.idx] = r.ent_valid;
            map_code[r.idx]  = r.ent_code;
            map_kind[r.idx]  = r.ent_kind;
            map_ctrl[r.idx]  = r.ent_ctrl;
            map_dir[r.idx]   = r.ent_dir;
            map_dz[r.idx]    = r.ent_dz;
            return;
        end
        if (r.ev_kind[INIT_BIT])
            return;
        both   = 1'b0;
        code_b = 8'd0;
        lvl    = int'(r.ev_level);
        code_a = lookup_code(r.ev_kind, r.ev_ctrl, lvl);
        // axis settled at center: release both directions
        if (lvl == 0 && r.ev_kind == KIND_AXIS)
        begin
            probe  = 1;
            code_a = lookup_code(r.ev_kind, r.ev_ctrl, probe);
            probe  = -1;
            code_b = lookup_code(r.ev_kind, r.ev_ctrl, probe);
            both   = 1'b1;
        end
        if (lvl != 0)
            pressed_flag = 1'b1;
        key_q.push_back({code_a, lvl[15:0], ~both, pressed_flag});
        if (both)
            key_q.push_back({code_b, 16'sd0, 1'b1, pressed_flag});
    endfunction

    function automatic pad_req_t noise_req();
        pad_req_t r;
        r.op        = 1'($urandom_range(0, 1));
        r.idx       = 6'($urandom_range(0, 63));
        r.ent_valid = 1'($urandom_range(0, 1));
        r.ent_code  = 8'($urandom);
        r.ent_kind  = 2'($urandom_range(0, 2));
        r.ent_ctrl  = 8'($urandom);
        r.ent_dir   = 2'($urandom_range(0, 2) - 1);
        r.ent_dz    = 16'($urandom);
        r.ev_kind   = 8'($urandom);
        r.ev_ctrl   = 8'($urandom);
        r.ev_level  = 16'($urandom);
        return r;
    endfunction

    function automatic pad_req_t ld_req(input int slot, input logic vld, input int code,
                                        input int kind, input int ctrl, input int dir,
                                        input int dz);
        pad_req_t r;
        r           = noise_req();
        r.op        = OP_LOAD;
        r.idx       = 6'(slot);
        r.ent_valid = vld;
        r.ent_code  = 8'(code);
        r.ent_kind  = 2'(kind);
        r.ent_ctrl  = 8'(ctrl);
        r.ent_dir   = 2'(dir);
        r.ent_dz    = 16'(dz);
        return r;
    endfunction

    function automatic pad_req_t ev_req(input logic [7:0] kind, input int ctrl,
                                        input int lvl);
        pad_req_t r;
        r          = noise_req();
        r.op       = OP_EVENT;
        r.ev_kind  = kind;
        r.ev_ctrl  = 8'(ctrl);
        r.ev_level = 16'(lvl);
        return r;
    endfunction

    // mostly plausible entries: few controls so events hit, mixed deadzones
    function automatic pad_req_t rand_entry(input int slot, input logic vld);
        int code;
        int kind;
        int ctrl;
        int dz;
        code = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
        kind = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        ctrl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        case ($urandom_range(0, 5))
            0, 1:    dz = 0;
            2:       dz = $urandom_range(1, 20000);
            3:       dz = -$urandom_range(1, 32768);
            4:       dz = $urandom_range(0, 1) ? 32767 : -32768;
            default: dz = $urandom_range(0, 65535) - 32768;
        endcase
        return ld_req(slot, vld, code, kind, ctrl, $urandom_range(0, 2) - 1, dz);
    endfunction

    function automatic pad_req_t rand_event(input int n);
        pad_req_t r;
        int       j;
        int       lvl;
        j = $urandom_range(0, n - 1);
        case ($urandom_range(0, 7))
            0:       lvl = 0;
            1:       lvl = 1;
            2:       lvl = $urandom_range(0, 4) - 2;
            3:       lvl = int'(map_dz[j]) + $urandom_range(0, 2) - 1;
            4:       lvl = $urandom_range(0, 1) ? 32767 : -32768;
            default: lvl = $urandom_range(0, 65535) - 32768;
        endcase
        r = ev_req({6'd0, map_kind[j]}, int'(map_ctrl[j]), lvl);
        if ($urandom_range(0, 15) == 0)
            r.ev_kind[INIT_BIT] = 1'b1;
        return r;
    endfunction

    task automatic send_req(input pad_req_t r);
        operation       <= r.op;
        entry_index     <= r.idx;
        entry_valid     <= r.ent_valid;
        entry_code      <= r.ent_code;
        entry_kind      <= r.ent_kind;
        entry_control   <= r.ent_ctrl;
        entry_direction <= r.ent_dir;
        entry_deadzone  <= r.ent_dz;
        event_kind      <= r.ev_kind;
        event_control   <= r.ev_ctrl;
        event_level     <= r.ev_level;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_keys(r);
        if (!(r.op == OP_EVENT && r.ev_kind[INIT_BIT]))
            sent_count++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX))
                @(posedge clk);
        end
    endtask

    // hold off requests until every pending key result has drained
    task automatic wait_for_keys();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (key_q.size() != 0);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 30;
        endcase
    endfunction

    task automatic load_rand_map(input int n);
        for (int s = 0; s < n; s++)
            send_req(rand_entry(s, 1'b1));
        if (n < TABLE_ENTRIES)
            send_req(rand_entry(n, 1'b0));
    endtask

    task automatic test_empty_map();
        send_req(ev_req(KIND_BUTTON, 0, 0));
        send_req(ev_req(KIND_AXIS, 3, 0));
        send_req(ev_req(KIND_AXIS, 3, -32768));
        send_req(ev_req(8'h82, 1, 5));
        send_req(ev_req(KIND_BUTTON, 9, 32767));
    endtask

    task automatic test_directed_map();
        send_req(ld_req(0, 1'b1, 'h10, 1, 0, 1, 0));
        send_req(ld_req(1, 1'b1, 'h20, 2, 1, 1, 8000));
        send_req(ld_req(2, 1'b1, 'h21, 2, 1, -1, 8000));
        // code zero trigger entry reshapes, the next entry reports
        send_req(ld_req(3, 1'b1, 'h00, 2, 2, 1, -16384));
        send_req(ld_req(4, 1'b1, 'h30, 2, 2, 1, 0));
        // odd direction pattern matches a raw button value of -2, or of 0
        send_req(ld_req(5, 1'b1, 'hFF, 1, 255, -2, -32768));
        send_req(ld_req(6, 1'b1, 'h40, 0, 0, 0, 32767));
        send_req(ld_req(7, 1'b0, 'h00, 0, 0, 0, 0));
        send_req(ld_req(63, 1'b1, 'h55, 1, 7, 1, 0));
        send_req(ev_req(KIND_BUTTON, 0, 1));
        send_req(ev_req(KIND_BUTTON, 0, 0));
        send_req(ev_req(KIND_AXIS, 1, 32767));
        send_req(ev_req(KIND_AXIS, 1, -32768));
        send_req(ev_req(KIND_AXIS, 1, 100));
        send_req(ev_req(KIND_AXIS, 2, 5000));
        send_req(ev_req(KIND_AXIS, 2, -20000));
        send_req(ev_req(KIND_BUTTON, 255, -2));
        send_req(ev_req(8'd0, 0, 5));
        send_req(ev_req(8'd0, 0, 0));
        send_req(ev_req(8'h7F, 0, 0));
        send_req(ev_req(8'hFF, 7, 1));
        send_req(ev_req(KIND_BUTTON, 7, 1));
    endtask

    task automatic test_full_map();
        gap_pct   = 20;
        stall_pct = 20;
        load_rand_map(TABLE_ENTRIES);
        send_req(ev_req(KIND_BUTTON, 7, 1));
        repeat (120)
            send_req(rand_event(TABLE_ENTRIES));
        wait_for_keys();
    endtask

    task automatic test_random_maps();
        int n;
        int phase;
        phase = 0;
        while (sent_count < ITEM_TARGET - TAIL_ITEMS)
        begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, TABLE_ENTRIES)
                                            : $urandom_range(1, 12);
            load_rand_map(n);
            repeat ($urandom_range(10, 40))
            begin
                if ($urandom_range(0, 99) < 15)
                    send_req(noise_req());
                else
                    send_req(rand_event(n));
            end
            if (phase % 4 == 0)
                wait_for_keys();
            phase++;
        end
    endtask

    task automatic test_back_to_back();
        int n;
        gap_pct   = 0;
        stall_pct = 0;
        n = $urandom_range(2, 10);
        load_rand_map(n);
        repeat (TAIL_ITEMS)
            send_req(rand_event(n));
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, BURST_MAX - 1);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        key_res_t got;
        key_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {key_code, key_level, last_result, any_press_seen};
            if (key_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("mismatch: unexpected key code %0h level %0d",
                             got.code, got.level,
                             " last %0b press %0b", got.last, got.press);
            end
            else
            begin
                want = key_q.pop_front();
                if (got.code !== want.code || got.level !== want.level ||
                    got.last !== want.last || got.press !== want.press)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: exp code %0h level %0d last %0b press %0b,",
                                 want.code, want.level, want.last, want.press,
                                 " got code %0h level %0d last %0b press %0b",
                                 got.code, got.level, got.last, got.press);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < TABLE_ENTRIES; s++)
        begin
            map_valid[s] = 1'b0;
            map_code[s]  = '0;
            map_kind[s]  = '0;
            map_ctrl[s]  = '0;
            map_dir[s]   = '0;
            map_dz[s]    = '0;
        end
        pressed_flag = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_map();
        test_directed_map();
        test_full_map();
        test_random_maps();
        test_back_to_back();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (key_q.size() != 0);
        repeat (SCAN_CYCLES + 20)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
